FILE: sv/lpl_pkg.sv
`default_nettype none
package lpl_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 256;
  localparam int unsigned LABEL_W = 32;
  localparam int unsigned POS_W = 8;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef logic signed [LABEL_W-1:0] label_t;
  typedef logic [POS_W-1:0] pos_t;

endpackage
`default_nettype wire

FILE: sv/lpl_if.sv
`default_nettype none
interface lpl_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  lpl_pkg::label_t   label;
  logic              first_entry;

  modport source (output valid, output kind, output label, output first_entry, input ready);
  modport sink (input valid, input kind, input label, input first_entry, output ready);
endinterface

interface lpl_out_if;
  logic            valid;
  logic            ready;
  logic            found;
  lpl_pkg::pos_t   position;
  logic            overflowed;

  modport source (output valid, output found, output position, output overflowed, input ready);
  modport sink (input valid, input found, input position, input overflowed, output ready);
endinterface
`default_nettype wire

FILE: sv/lpl_store.sv
`default_nettype none
module lpl_store #(
  parameter int unsigned MAX_ENTRIES = lpl_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire lpl_pkg::label_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output lpl_pkg::label_t      rd_data
);

  lpl_pkg::label_t mem [MAX_ENTRIES];
  lpl_pkg::label_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: sv/lpl_ctrl.sv
`default_nettype none
module lpl_ctrl #(
  parameter int unsigned MAX_ENTRIES = lpl_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  lpl_in_if.sink               in_ch,
  lpl_out_if.source            out_ch,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output lpl_pkg::label_t      wr_data,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  wire lpl_pkg::label_t rd_data
);

  lpl_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CW-1:0]   left_r, left_nxt;
  logic [AW-1:0]   rd_addr_r, rd_addr_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]   cmp_addr_r;
  lpl_pkg::label_t key_r, key_nxt;
  logic            res_found_r, res_found_nxt;
  logic [AW-1:0]   res_pos_r, res_pos_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_found_r, out_found_nxt;
  lpl_pkg::pos_t   out_pos_r, out_pos_nxt;
  logic            out_ovf_r, out_ovf_nxt;
  logic            full;
  logic            hit;

  assign full = (count_r == CW'(MAX_ENTRIES));
  assign hit  = cmp_vld_r && (rd_data == key_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    left_nxt      = left_r;
    rd_addr_nxt   = rd_addr_r;
    key_nxt       = key_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_ovf_nxt   = out_ovf_r;
    in_ch.ready   = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    rd_en         = 1'b0;

    // drop the held word once the receiver takes it
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      lpl_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.kind == lpl_pkg::KIND_LOAD) begin
            if (in_ch.first_entry) begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              count_nxt = CW'(1);
              ovf_nxt   = 1'b0;
            end else if (full) begin
              ovf_nxt = 1'b1;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else begin
            key_nxt = in_ch.label;
            if (count_r == '0) begin
              res_found_nxt = 1'b0;
              res_pos_nxt   = '0;
              state_nxt     = lpl_pkg::ST_FINISH;
            end else begin
              left_nxt    = count_r;
              rd_addr_nxt = AW'(count_r - CW'(1));
              state_nxt   = lpl_pkg::ST_SCAN;
            end
          end
        end
      end
      lpl_pkg::ST_SCAN: begin
        // walk down from the top entry; the first match is the highest position
        rd_en = (left_r != '0) && !hit;
        if (rd_en) begin
          rd_addr_nxt = rd_addr_r - AW'(1);
          left_nxt    = left_r - CW'(1);
        end
        if (hit) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = cmp_addr_r;
          state_nxt     = lpl_pkg::ST_FINISH;
        end else if (cmp_vld_r && (cmp_addr_r == '0)) begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = lpl_pkg::ST_FINISH;
        end
      end
      lpl_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = lpl_pkg::POS_W'(res_pos_r);
          out_ovf_nxt   = ovf_r;
          state_nxt     = lpl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lpl_pkg::ST_IDLE;
      end
    endcase
  end

  assign cmp_vld_nxt = rd_en;
  assign wr_data     = in_ch.label;
  assign rd_addr     = rd_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpl_pkg::ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r      <= left_nxt;
    rd_addr_r   <= rd_addr_nxt;
    key_r       <= key_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_ovf_r   <= out_ovf_nxt;
    if (rd_en) begin
      cmp_addr_r <= rd_addr_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.position   = out_pos_r;
  assign out_ch.overflowed = out_ovf_r;

endmodule
`default_nettype wire

FILE: sv/label_to_position_lookup_top.sv
// Label-to-position lookup.
// in_ch carries words of kind, label and first_entry. A load word (kind 0)
// appends its label to the list; first_entry empties the list and clears
// the overflow flag first. Loads into a full list are dropped and set the
// overflow flag. Loads give no result word.
// A lookup word (kind 1) scans the stored labels from the highest position
// down with one 32-bit comparator, one entry per cycle, reading a label RAM
// with a registered read. It returns one word on out_ch: found,
// the highest matching position (low 8 bits) and the overflow flag.
// A scan stops at the first match or after the entries held (MAX_ENTRIES at
// most). A new lookup is accepted only once the last one has put its word
// in the out_ch register; in_ch.ready is low during a scan. Loads are
// taken one per cycle while no lookup is in progress.
// out_ch is a held output register: while the receiver stalls the word is
// kept, loads are still accepted, and a finished lookup waits for the slot.
// Reset (rst_n low, synchronous) empties the list, clears the overflow flag
// and drops any pending result; the label RAM itself is not cleared.
`default_nettype none
module label_to_position_lookup_top #(
  parameter int unsigned MAX_ENTRIES = lpl_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lpl_in_if.sink     in_ch,
  lpl_out_if.source  out_ch
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  lpl_pkg::label_t wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  lpl_pkg::label_t rd_data;

  lpl_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lpl_store #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

FILE: sv/lpl_checker.sv
`default_nettype none
module lpl_checker (
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire logic  in_kind,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire logic  out_found,
  input wire logic [lpl_pkg::POS_W-1:0] out_position,
  input wire logic  out_overflowed
);

  // reset drops any pending result
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // a lookup drops input ready in the cycle after it is accepted
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == lpl_pkg::KIND_LOOKUP)) |=> !in_ready)
    else $error("input ready right after a lookup");

  // a load never creates a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == lpl_pkg::KIND_LOAD) && !out_valid) |=> !out_valid)
    else $error("result word after a load");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_found)
      && $stable(out_position) && $stable(out_overflowed)))
    else $error("stalled result word changed");

endmodule

bind label_to_position_lookup_top lpl_checker u_lpl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_kind        (in_ch.kind),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_found      (out_ch.found),
  .out_position   (out_ch.position),
  .out_overflowed (out_ch.overflowed)
);
`default_nettype wire
